// ----- rtl/core/kss_pkg.sv -----
// Shared constants, types and helpers for the keyed string store.
// No dependencies; every module of the block imports this package.
`default_nettype none

package kss_pkg;

	localparam int ENTRIES     = 32;
	localparam int NAME_BYTES  = 64;
	localparam int VALUE_BYTES = 128;

	localparam int NAME_WORDS  = (NAME_BYTES + 7) / 8;
	localparam int VALUE_WORDS = (VALUE_BYTES + 7) / 8;
	localparam int COPY_WORDS  = NAME_WORDS + VALUE_WORDS;

	localparam int ENT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NW_W  = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
	localparam int VW_W  = (VALUE_WORDS > 1) ? $clog2(VALUE_WORDS) : 1;
	localparam int NC_W  = $clog2(NAME_BYTES + 1);
	localparam int NL_W  = $clog2(NAME_BYTES);
	localparam int VC_W  = $clog2(VALUE_BYTES);
	localparam int CP_W  = $clog2(COPY_WORDS);

	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOTFOUND  = 2'd3
	} kss_status_t;

	// one operation handed from the parser when a final byte is taken
	typedef struct packed {
		logic            valid;
		logic            is_get;
		logic            malformed;
		logic [NC_W-1:0] nlen;
		logic [VC_W-1:0] vlen;
	} kss_op_t;

	typedef struct packed {
		logic                 name_re;
		logic                 name_we;
		logic [ENT_W+NW_W-1:0] name_addr;
		logic [63:0]          name_wdata;
		logic                 value_re;
		logic                 value_we;
		logic [ENT_W+VW_W-1:0] value_addr;
		logic [63:0]          value_wdata;
	} kss_tbl_req_t;

	// keep the low n byte lanes of a word
	function automatic logic [63:0] lane_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[i*8 +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/kss_parser.sv -----
// Byte parser with the scratch name and value memories.
// Depends on kss_pkg.
`default_nettype none

module kss_parser import kss_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            beat,
	input  wire logic            cmd,
	input  wire logic [7:0]      byte_in,
	input  wire logic            last_byte,
	output kss_op_t              op,
	input  wire logic            scr_re,
	input  wire logic [NW_W-1:0] name_raddr,
	input  wire logic [VW_W-1:0] value_raddr,
	output logic [63:0]          name_rdata,
	output logic [63:0]          value_rdata
);

	typedef enum logic [2:0] {
		PH_NAME  = 3'b001,
		PH_VALUE = 3'b010,
		PH_DONE  = 3'b100
	} phase_t;

	phase_t          phase_q, phase_nx;
	logic [NC_W-1:0] nc_q, nc_nx;
	logic [VC_W-1:0] vc_q, vc_nx;
	logic            nwr, vwr;
	kss_op_t         op_q;

	logic [63:0] scr_name_mem  [NAME_WORDS];
	logic [63:0] scr_value_mem [VALUE_WORDS];

	always_comb begin
		phase_nx = phase_q;
		nc_nx    = nc_q;
		vc_nx    = vc_q;
		nwr      = 1'b0;
		vwr      = 1'b0;
		case (phase_q)
			PH_NAME: begin
				if (!cmd && byte_in == CH_EQ) begin
					phase_nx = PH_VALUE;
				end else begin
					nwr = (nc_q < NC_W'(NAME_BYTES - 1));
					if (nc_q < NC_W'(NAME_BYTES)) nc_nx = nc_q + 1'b1;
				end
			end
			PH_VALUE: begin
				if (byte_in == CH_SEMI) begin
					phase_nx = PH_DONE;
				end else if (vc_q < VC_W'(VALUE_BYTES - 1)) begin
					vwr   = 1'b1;
					vc_nx = vc_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAME;
			nc_q    <= '0;
			vc_q    <= '0;
			op_q    <= '0;
		end else begin
			op_q.valid <= 1'b0;
			if (beat) begin
				if (last_byte) begin
					phase_q        <= PH_NAME;
					nc_q           <= '0;
					vc_q           <= '0;
					op_q.valid     <= 1'b1;
					op_q.is_get    <= cmd;
					op_q.malformed <= !cmd && (phase_nx == PH_NAME);
					op_q.vlen      <= vc_nx;
					if (!cmd && nc_nx > NC_W'(NAME_BYTES - 1))
						op_q.nlen <= NC_W'(NAME_BYTES - 1);
					else
						op_q.nlen <= nc_nx;
				end else begin
					phase_q <= phase_nx;
					nc_q    <= nc_nx;
					vc_q    <= vc_nx;
				end
			end
		end
	end

	// byte-lane writes into the scratch words, registered reads
	always_ff @(posedge clk) begin
		if (beat && nwr)
			scr_name_mem[nc_q[NW_W+2:3]][{nc_q[2:0], 3'b000} +: 8] <= byte_in;
		if (beat && vwr)
			scr_value_mem[vc_q[VW_W+2:3]][{vc_q[2:0], 3'b000} +: 8] <= byte_in;
		if (scr_re) begin
			name_rdata  <= scr_name_mem[name_raddr];
			value_rdata <= scr_value_mem[value_raddr];
		end
	end

	assign op = op_q;

endmodule

`default_nettype wire

// ----- rtl/core/kss_table.sv -----
// Name and value stores of all entries, one word per access.
// Depends on kss_pkg.
`default_nettype none

module kss_table import kss_pkg::*; (
	input  wire logic         clk,
	input  wire kss_tbl_req_t req,
	output logic [63:0]       name_rdata,
	output logic [63:0]       value_rdata
);

	logic [63:0] name_mem  [ENTRIES*NAME_WORDS];
	logic [63:0] value_mem [ENTRIES*VALUE_WORDS];

	always_ff @(posedge clk) begin
		if (req.name_we) name_mem[req.name_addr] <= req.name_wdata;
		if (req.name_re) name_rdata <= name_mem[req.name_addr];
	end

	always_ff @(posedge clk) begin
		if (req.value_we) value_mem[req.value_addr] <= req.value_wdata;
		if (req.value_re) value_rdata <= value_mem[req.value_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/keyed_string_store_unit.sv -----
// Keyed string store: byte beats are taken only while the unit is idle.
// On the final byte of a well-formed operation the entries are scanned, comparing
// name words of each entry whose name length matches; a set then copies 24 scratch
// words into a slot, a get returns the value one word at a time.
// One operation at a time. Reset clears all used marks at once; no clearing pass.
`default_nettype none

module keyed_string_store_unit import kss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [7:0]  byte_in,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [63:0]      value_word,
	output logic [3:0]       word_bytes,
	output logic             last_result
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_SCAN = 8'b00000010,
		S_CMP  = 8'b00000100,
		S_COPY = 8'b00001000,
		S_CFIN = 8'b00010000,
		S_GRD  = 8'b00100000,
		S_GWT  = 8'b01000000,
		S_EMIT = 8'b10000000
	} state_t;

	state_t            state_q;
	kss_op_t           op;
	kss_tbl_req_t      treq;
	logic [63:0]       tbl_name_rd, tbl_value_rd, scr_name_rd, scr_value_rd;
	logic              scr_re;
	logic [NW_W-1:0]   scr_name_addr;
	logic [VW_W-1:0]   scr_value_addr;

	logic [ENT_W-1:0]  ent_q, slot_q, free_q;
	logic              free_vld_q;
	logic [VW_W-1:0]   w_q, w_nx;
	logic              is_get_q;
	logic [NC_W-1:0]   nlen_q;
	logic [VC_W-1:0]   vlen_q;
	logic [CP_W-1:0]   cp_q;
	logic              cp_vld_s1;
	logic [CP_W-1:0]   cp_idx_s1;
	kss_status_t       res_q;

	logic              used_q     [ENTRIES];
	logic [NL_W-1:0]   name_len_q [ENTRIES];
	logic [VC_W-1:0]   val_len_q  [ENTRIES];

	logic              out_valid_q;
	kss_status_t       out_st_q;
	logic [63:0]       out_word_q;
	logic [3:0]        out_nb_q;
	logic              out_last_q;

	logic              beat, out_free;
	logic              cur_used, len_eq, name_eq, name_last, val_last;
	logic [NC_W-1:0]   rem_n;
	logic [VC_W-1:0]   vlen_e, rem_v;
	logic [3:0]        nb_n, nb_v;
	logic              free_now_vld;
	logic [ENT_W-1:0]  free_now;
	logic [CP_W-1:0]   vidx;

	assign beat     = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !op.valid;
	assign out_free = !out_valid_q || out_ready;

	kss_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (beat),
		.cmd         (cmd),
		.byte_in     (byte_in),
		.last_byte   (last_byte),
		.op          (op),
		.scr_re      (scr_re),
		.name_raddr  (scr_name_addr),
		.value_raddr (scr_value_addr),
		.name_rdata  (scr_name_rd),
		.value_rdata (scr_value_rd)
	);

	kss_table u_table (
		.clk         (clk),
		.req         (treq),
		.name_rdata  (tbl_name_rd),
		.value_rdata (tbl_value_rd)
	);

	assign w_nx     = w_q + 1'b1;
	assign cur_used = used_q[ent_q];
	assign len_eq   = cur_used && (NC_W'(name_len_q[ent_q]) == nlen_q);

	assign rem_n     = nlen_q - NC_W'({w_q[NW_W-1:0], 3'b000});
	assign nb_n      = (rem_n >= NC_W'(8)) ? 4'd8 : rem_n[3:0];
	assign name_last = (rem_n <= NC_W'(8));
	assign name_eq   = ((tbl_name_rd ^ scr_name_rd) & lane_mask(nb_n)) == 64'd0;

	assign vlen_e   = val_len_q[ent_q];
	assign rem_v    = vlen_e - VC_W'({w_q, 3'b000});
	assign nb_v     = (rem_v >= VC_W'(8)) ? 4'd8 : rem_v[3:0];
	assign val_last = (rem_v <= VC_W'(8));

	assign free_now_vld = free_vld_q || ((state_q == S_SCAN) && !cur_used);
	assign free_now     = free_vld_q ? free_q : ent_q;
	assign vidx         = cp_idx_s1 - CP_W'(NAME_WORDS);

	always_comb begin
		scr_re         = 1'b0;
		scr_name_addr  = '0;
		scr_value_addr = '0;
		treq           = '0;
		case (state_q)
			S_SCAN: begin
				scr_re         = 1'b1;
				treq.name_re   = 1'b1;
				treq.name_addr = {ent_q, {NW_W{1'b0}}};
			end
			S_CMP: begin
				scr_re         = 1'b1;
				scr_name_addr  = w_nx[NW_W-1:0];
				treq.name_re   = 1'b1;
				treq.name_addr = {ent_q, w_nx[NW_W-1:0]};
			end
			S_COPY: begin
				scr_re         = 1'b1;
				scr_name_addr  = cp_q[NW_W-1:0];
				scr_value_addr = VW_W'(cp_q - CP_W'(NAME_WORDS));
			end
			S_GRD: begin
				treq.value_re   = 1'b1;
				treq.value_addr = {ent_q, w_q};
			end
			default: ;
		endcase
		// write back the word read in the previous copy cycle
		if (cp_vld_s1) begin
			if (cp_idx_s1 < CP_W'(NAME_WORDS)) begin
				treq.name_we    = 1'b1;
				treq.name_addr  = {slot_q, cp_idx_s1[NW_W-1:0]};
				treq.name_wdata = scr_name_rd;
			end else begin
				treq.value_we    = 1'b1;
				treq.value_addr  = {slot_q, vidx[VW_W-1:0]};
				treq.value_wdata = scr_value_rd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cp_vld_s1   <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) used_q[i] <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == S_COPY);
			cp_idx_s1 <= cp_q;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (op.valid) begin
						is_get_q   <= op.is_get;
						nlen_q     <= op.nlen;
						vlen_q     <= op.vlen;
						ent_q      <= '0;
						free_vld_q <= 1'b0;
						if (op.malformed) begin
							res_q   <= ST_MALFORMED;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN, S_CMP: begin
					if ((state_q == S_SCAN && len_eq && nlen_q == '0) ||
					    (state_q == S_CMP && name_eq && name_last)) begin
						// hit on ent_q
						w_q    <= '0;
						slot_q <= ent_q;
						cp_q   <= '0;
						state_q <= is_get_q ? S_GRD : S_COPY;
					end else if (state_q == S_SCAN && len_eq) begin
						w_q     <= '0;
						state_q <= S_CMP;
					end else if (state_q == S_CMP && name_eq) begin
						w_q <= w_nx;
					end else begin
						if (free_now_vld && !free_vld_q) begin
							free_vld_q <= 1'b1;
							free_q     <= ent_q;
						end
						if (ent_q == ENT_W'(ENTRIES - 1)) begin
							if (is_get_q) begin
								res_q   <= ST_NOTFOUND;
								state_q <= S_EMIT;
							end else if (free_now_vld) begin
								slot_q  <= free_now;
								cp_q    <= '0;
								state_q <= S_COPY;
							end else begin
								res_q   <= ST_FULL;
								state_q <= S_EMIT;
							end
						end else begin
							ent_q   <= ent_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_COPY: begin
					if (cp_q == CP_W'(COPY_WORDS - 1)) state_q <= S_CFIN;
					else cp_q <= cp_q + 1'b1;
				end
				S_CFIN: begin
					used_q[slot_q]     <= 1'b1;
					name_len_q[slot_q] <= nlen_q[NL_W-1:0];
					val_len_q[slot_q]  <= vlen_q;
					res_q              <= ST_OK;
					state_q            <= S_EMIT;
				end
				S_GRD: begin
					if (vlen_e == '0) begin
						res_q   <= ST_OK;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_GWT;
					end
				end
				S_GWT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_st_q    <= ST_OK;
						out_word_q  <= tbl_value_rd & lane_mask(nb_v);
						out_nb_q    <= nb_v;
						out_last_q  <= val_last;
						if (val_last) begin
							state_q <= S_IDLE;
						end else begin
							w_q     <= w_nx;
							state_q <= S_GRD;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_st_q    <= res_q;
						out_word_q  <= '0;
						out_nb_q    <= '0;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign value_word  = out_word_q;
	assign word_bytes  = out_nb_q;
	assign last_result = out_last_q;

endmodule

`default_nettype wire
